/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue: depth, entry
// layout, action and status codes, and the control word of the cell chain
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W     = 7;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [ENTRY_W-1:0] entry_cnt_t;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic        [15:0] tag;
        logic signed [15:0] prio;
    } entry_t;

    typedef struct packed {
        logic ins_en;
        logic ext_en;
    } cell_ctrl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the queue chain; holds one entry and on each command either
// keeps it, takes the new entry, or takes its left or right neighbor's entry
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t    new_entry,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t data_reg;
    spq_pkg::entry_t data_next;

    // chain is in descending priority, so an entry of equal or higher
    // priority stays ahead of the new one
    assign keep = occupied && ($signed(data_reg.prio) >= $signed(new_entry.prio));

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.ext_en)
        begin
            data_next = right_entry;
        end
        else if (ctrl.ins_en)
        begin
            if (!left_keep)
            begin
                data_next = left_entry;
            end
            else if (!keep)
            begin
                data_next = new_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign entry = data_reg;

endmodule

/* hw/rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue
// bounded priority queue of (tag, priority) entries built as a chain of cells
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries action, item_tag, priority_req;
//   output channel (out_valid/out_ready) returns out_tag, out_priority,
//   status and entry_count, exactly one result per input transfer.
//   the chain is kept in descending priority with the oldest of equals first,
//   so the head cell always holds the entry that extract and peek return.
//   every cell compares its entry with the new priority in the same cycle and
//   shifts toward or away from the head, so an insert, extract, peek or clear
//   is done on the input transfer itself; the result sits in the output
//   register in the cycle after the input transfer.
//   throughput is one item per cycle while the receiver keeps up; the single
//   output register sets that figure.
//   in_ready is high whenever the output register is empty or being emptied;
//   a stalled receiver holds the result and blocks further input.
//   reset empties the queue (count goes to zero) and drops any pending
//   result; cell contents are not cleared and are never read before written.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [15:0] item_tag,
    input  logic signed [15:0] priority_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_tag,
    output logic signed [15:0] out_priority,
    output logic [1:0]  status,
    output logic [6:0]  entry_count
);

    localparam int Depth = spq_pkg::QUEUE_DEPTH;

    spq_pkg::count_t     count_reg;
    spq_pkg::count_t     count_next;
    logic                out_valid_reg;
    logic [15:0]         out_tag_reg;
    logic signed [15:0]  out_prio_reg;
    spq_pkg::status_t    status_reg;
    spq_pkg::entry_cnt_t entry_count_reg;

    spq_pkg::status_t    status_next;
    logic [15:0]         tag_next;
    logic signed [15:0]  prio_next;

    spq_pkg::entry_t     new_entry;
    spq_pkg::entry_t     cell_entry [Depth];
    logic [Depth-1:0]    cell_keep;
    spq_pkg::cell_ctrl_t ctrl;

    spq_pkg::action_t    act;
    logic                accept;
    logic                full;
    logic                empty;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign act      = spq_pkg::action_t'(action);
    assign full     = (count_reg == spq_pkg::count_t'(Depth));
    assign empty    = (count_reg == '0);

    assign new_entry.tag  = item_tag;
    assign new_entry.prio = priority_req;

    assign ctrl.ins_en = accept && (act == spq_pkg::ACT_INSERT) && !full;
    assign ctrl.ext_en = accept && (act == spq_pkg::ACT_EXTRACT) && !empty;

    genvar i;
    generate
        for (i = 0; i < Depth; i++)
        begin : g_cell
            logic            left_keep;
            spq_pkg::entry_t left_entry;
            spq_pkg::entry_t right_entry;

            if (i == 0)
            begin : g_head
                assign left_keep  = 1'b1;
                assign left_entry = new_entry;
            end
            else
            begin : g_body
                assign left_keep  = cell_keep[i-1];
                assign left_entry = cell_entry[i-1];
            end

            if (i == Depth - 1)
            begin : g_tail
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .occupied    (count_reg > spq_pkg::count_t'(i)),
                .left_keep   (left_keep),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .keep        (cell_keep[i]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next  = count_reg;
        status_next = spq_pkg::ST_DONE;
        tag_next    = '0;
        prio_next   = '0;
        case (act)
            spq_pkg::ACT_INSERT:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + spq_pkg::count_t'(1);
                end
            end
            spq_pkg::ACT_EXTRACT, spq_pkg::ACT_PEEK:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    tag_next  = cell_entry[0].tag;
                    prio_next = cell_entry[0].prio;
                    if (act == spq_pkg::ACT_EXTRACT)
                    begin
                        count_next = count_reg - spq_pkg::count_t'(1);
                    end
                end
            end
            spq_pkg::ACT_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_tag_reg     <= tag_next;
            out_prio_reg    <= prio_next;
            status_reg      <= status_next;
            entry_count_reg <= spq_pkg::entry_cnt_t'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

endmodule

/* dv/spq_tb_pkg.sv */
// ----------------------------------------------------------------------------
// spq_tb_pkg
// scoreboard for the sorted priority queue: keeps its own sorted copy of the
// queue, works out the result of every accepted action and checks the
// results that come back in order
// ----------------------------------------------------------------------------
package spq_tb_pkg;

    import spq_pkg::*;

    class spq_scoreboard;

        typedef struct {
            logic [15:0]        tag;
            logic signed [15:0] prio;
            status_t            st;
            entry_cnt_t         cnt;
        } queue_result_t;

        // ascending priority, oldest of equals in the lowest slot
        logic [15:0]        slot_tag  [QUEUE_DEPTH];
        logic signed [15:0] slot_prio [QUEUE_DEPTH];
        int                 fill;
        queue_result_t      awaited_results [$];
        int unsigned        errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void note_request(action_t act, logic [15:0] tag, logic signed [15:0] prio);
            queue_result_t r;
            int            pos;
            int            k;
            r.tag  = '0;
            r.prio = '0;
            r.st   = ST_DONE;
            case (act)
                ACT_INSERT:
                begin
                    if (fill >= QUEUE_DEPTH)
                    begin
                        r.st = ST_FULL;
                    end
                    else
                    begin
                        pos = 0;
                        while (pos < fill && slot_prio[pos] <= prio)
                            pos++;
                        for (k = fill; k > pos; k--)
                        begin
                            slot_tag[k]  = slot_tag[k-1];
                            slot_prio[k] = slot_prio[k-1];
                        end
                        slot_tag[pos]  = tag;
                        slot_prio[pos] = prio;
                        fill++;
                    end
                end
                ACT_EXTRACT, ACT_PEEK:
                begin
                    if (fill == 0)
                    begin
                        r.st = ST_EMPTY;
                    end
                    else
                    begin
                        // walk down to the oldest entry of the top priority
                        k = fill - 1;
                        while (k > 0 && slot_prio[k-1] == slot_prio[fill-1])
                            k--;
                        r.tag  = slot_tag[k];
                        r.prio = slot_prio[k];
                        if (act == ACT_EXTRACT)
                        begin
                            fill--;
                            for (; k < fill; k++)
                            begin
                                slot_tag[k]  = slot_tag[k+1];
                                slot_prio[k] = slot_prio[k+1];
                            end
                        end
                    end
                end
                default:
                begin
                    fill = 0;
                end
            endcase
            r.cnt = entry_cnt_t'(fill);
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic [15:0] tag, logic signed [15:0] prio,
                                   logic [1:0] st, logic [6:0] cnt);
            queue_result_t r;
            if (awaited_results.size() == 0)
            begin
                $error("result transfer with no action waiting");
                errors++;
                return;
            end
            r = awaited_results.pop_front();
            if (tag !== r.tag)
            begin
                $error("out_tag: expected %h, actual %h", r.tag, tag);
                errors++;
            end
            if (prio !== r.prio)
            begin
                $error("out_priority: expected %0d, actual %0d", r.prio, prio);
                errors++;
            end
            if (st !== r.st)
            begin
                $error("status: expected %0d, actual %0d", r.st, st);
                errors++;
            end
            if (cnt !== r.cnt)
            begin
                $error("entry_count: expected %0d, actual %0d", r.cnt, cnt);
                errors++;
            end
        endfunction

    endclass

endpackage

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// testbench of the sorted priority queue: a directed pass over empty, tie and
// extreme-priority cases, then random segments that fill and drain the queue,
// with random gaps on both channels and one long receiver stall
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;
    import spq_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SEGMENTS     = 10;
    localparam int SEGMENT_LEN  = 95;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic [1:0]         action       = ACT_INSERT;
    logic [15:0]        item_tag     = '0;
    logic signed [15:0] priority_req = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [15:0]        out_tag;
    logic signed [15:0] out_priority;
    logic [1:0]         status;
    logic [6:0]         entry_count;

    spq_scoreboard sb = new();

    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;
    int cycles       = 0;

    sorted_priority_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .item_tag     (item_tag),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .status       (status),
        .entry_count  (entry_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    // both channels sampled at the edge, before any update of this step
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(action_t'(action), item_tag, priority_req);
            if (out_valid && out_ready)
                sb.check_result(out_tag, out_priority, status, entry_count);
        end
    end

    task automatic send_action(action_t act, logic [15:0] tag, logic signed [15:0] prio);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        item_tag     <= tag;
        priority_req <= prio;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] draw_priority();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return 16'($signed($urandom_range(0, 6)) - 3);
        if (mode == 4)
        begin
            case ($urandom_range(0, 5))
                0:       return -16'sd32768;
                1:       return -16'sd32767;
                2:       return -16'sd1;
                3:       return 16'sd0;
                4:       return 16'sd32766;
                default: return 16'sd32767;
            endcase
        end
        return 16'($urandom);
    endfunction

    // receiver: random hold-off per result, or one long stall on request
    initial
    begin
        int gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int         seg;
        int         n;
        int         ins_pct;
        int         pick;
        action_t    act;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty refusals, extremes, ties, clear with entries
        send_action(ACT_EXTRACT, 16'($urandom), 16'($urandom));
        send_action(ACT_PEEK,    16'($urandom), 16'($urandom));
        send_action(ACT_CLEAR,   16'($urandom), 16'($urandom));
        send_action(ACT_INSERT,  16'h0000, -16'sd32768);
        send_action(ACT_INSERT,  16'hffff, 16'sd32767);
        send_action(ACT_INSERT,  16'h1234, 16'sd0);
        send_action(ACT_INSERT,  16'h5678, 16'sd0);
        send_action(ACT_INSERT,  16'h9abc, 16'sd32767);
        send_action(ACT_PEEK,    16'hffff, 16'sd0);
        send_action(ACT_EXTRACT, 16'h0000, -16'sd1);
        send_action(ACT_EXTRACT, 16'hffff, 16'sd32767);
        send_action(ACT_PEEK,    16'h0000, -16'sd32768);
        send_action(ACT_EXTRACT, 16'($urandom), 16'($urandom));
        send_action(ACT_EXTRACT, 16'($urandom), 16'($urandom));
        send_action(ACT_INSERT,  16'haaaa, -16'sd1);
        send_action(ACT_INSERT,  16'h5555, -16'sd32768);
        send_action(ACT_EXTRACT, 16'($urandom), 16'($urandom));
        send_action(ACT_EXTRACT, 16'($urandom), 16'($urandom));
        send_action(ACT_PEEK,    16'($urandom), 16'($urandom));
        send_action(ACT_CLEAR,   16'($urandom), 16'($urandom));
        send_action(ACT_PEEK,    16'($urandom), 16'($urandom));
        send_action(ACT_INSERT,  16'h8001, -16'sd32767);
        send_action(ACT_EXTRACT, 16'($urandom), 16'($urandom));

        // random segments, each with its own insert bias
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 5)
                0:       ins_pct = 95;
                1:       ins_pct = 15;
                2:       ins_pct = 55;
                3:       ins_pct = 75;
                default: ins_pct = 35;
            endcase
            gaps_on = (seg == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            if (seg == 3)
                hold_request = 1'b1;
            for (n = 0; n < SEGMENT_LEN; n++)
            begin
                if ($urandom_range(0, 99) < ins_pct)
                begin
                    act = ACT_INSERT;
                end
                else
                begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        act = ACT_CLEAR;
                    else if (pick < 7)
                        act = ACT_PEEK;
                    else
                        act = ACT_EXTRACT;
                end
                send_action(act, 16'($urandom), draw_priority());
            end
        end

        in_valid <= 1'b0;
        // let the monitor note the last transfer before counting what is left
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule
